[rtl/pfc_pkg.sv]
// Package for the PID feedforward controller: widths, codes, state and command types.
// No dependencies.
package pfc_pkg;

   localparam int DataWidth = 32;
   localparam int FracBits  = 16;
   localparam int LimWidth  = 31;
   localparam int WgtWidth  = 17;
   localparam int IdxWidth  = 3;

   localparam logic [DataWidth-1:0] DtDefault = 32'd655;
   localparam logic [WgtWidth-1:0]  WgtOne    = 17'd65536;

   // register indexes
   localparam logic [IdxWidth-1:0] RegGainP   = 3'd0;
   localparam logic [IdxWidth-1:0] RegGainI   = 3'd1;
   localparam logic [IdxWidth-1:0] RegGainD   = 3'd2;
   localparam logic [IdxWidth-1:0] RegGainFf  = 3'd3;
   localparam logic [IdxWidth-1:0] RegIntLim  = 3'd4;
   localparam logic [IdxWidth-1:0] RegOutLim  = 3'd5;
   localparam logic [IdxWidth-1:0] RegWeight  = 3'd6;

   typedef enum logic [3:0] {
      ST_IDLE, ST_CLEAR, ST_INTEG, ST_INTCLAMP, ST_DIFF, ST_DIV, ST_DIVFIN,
      ST_EMA_A, ST_EMA_B, ST_EMA_FIN, ST_TERM_P, ST_TERM_I, ST_TERM_D,
      ST_TERM_FF, ST_OUT, ST_HOLD
   } state_type;

   typedef struct packed {
      logic load;      // capture input item
      logic clear;     // zero state, zero result
      logic integ;     // integral += err*dt
      logic intclamp;  // clamp integral
      logic diff;      // error difference, start divide
      logic div_step;  // one divider iteration
      logic div_fin;   // finish divide
      logic ema_a;     // alpha*raw
      logic ema_b;     // add (1-alpha)*last
      logic ema_fin;   // shift, update state
      logic term_p;
      logic term_i;
      logic term_d;
      logic term_ff;
      logic out_fin;   // clamp output into result register
   } cmd_type;

   typedef struct packed {
      logic div_done;
   } sts_type;

   // saturate a 66-bit signed value to 32 bits
   function automatic logic [DataWidth-1:0] sat66(input logic signed [65:0] v);
      logic [DataWidth-1:0] r;
      if (v > 66'sh0_7FFF_FFFF) r = 32'h7FFF_FFFF;
      else if (v < -66'sh0_8000_0000) r = 32'h8000_0000;
      else r = v[DataWidth-1:0];
      return r;
   endfunction

endpackage

[rtl/pfc_ctrl.sv]
// Controller state machine for the PID feedforward controller.
// Depends on pfc_pkg.
module pfc_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic             req_op,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   input  pfc_pkg::sts_type sts,
   output pfc_pkg::cmd_type cmd
);

   pfc_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pfc_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      unique case (state_ff)
         pfc_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = req_op ? pfc_pkg::ST_CLEAR : pfc_pkg::ST_INTEG;
            end
         end
         pfc_pkg::ST_CLEAR: begin
            cmd.clear = 1'b1;
            state_in  = pfc_pkg::ST_HOLD;
         end
         pfc_pkg::ST_INTEG: begin
            cmd.integ = 1'b1;
            state_in  = pfc_pkg::ST_INTCLAMP;
         end
         pfc_pkg::ST_INTCLAMP: begin
            cmd.intclamp = 1'b1;
            state_in     = pfc_pkg::ST_DIFF;
         end
         pfc_pkg::ST_DIFF: begin
            cmd.diff = 1'b1;
            state_in = pfc_pkg::ST_DIV;
         end
         pfc_pkg::ST_DIV: begin
            cmd.div_step = 1'b1;
            if (sts.div_done) state_in = pfc_pkg::ST_DIVFIN;
         end
         pfc_pkg::ST_DIVFIN: begin
            cmd.div_fin = 1'b1;
            state_in    = pfc_pkg::ST_EMA_A;
         end
         pfc_pkg::ST_EMA_A: begin
            cmd.ema_a = 1'b1;
            state_in  = pfc_pkg::ST_EMA_B;
         end
         pfc_pkg::ST_EMA_B: begin
            cmd.ema_b = 1'b1;
            state_in  = pfc_pkg::ST_EMA_FIN;
         end
         pfc_pkg::ST_EMA_FIN: begin
            cmd.ema_fin = 1'b1;
            state_in    = pfc_pkg::ST_TERM_P;
         end
         pfc_pkg::ST_TERM_P: begin
            cmd.term_p = 1'b1;
            state_in   = pfc_pkg::ST_TERM_I;
         end
         pfc_pkg::ST_TERM_I: begin
            cmd.term_i = 1'b1;
            state_in   = pfc_pkg::ST_TERM_D;
         end
         pfc_pkg::ST_TERM_D: begin
            cmd.term_d = 1'b1;
            state_in   = pfc_pkg::ST_TERM_FF;
         end
         pfc_pkg::ST_TERM_FF: begin
            cmd.term_ff = 1'b1;
            state_in    = pfc_pkg::ST_OUT;
         end
         pfc_pkg::ST_OUT: begin
            cmd.out_fin = 1'b1;
            state_in    = pfc_pkg::ST_HOLD;
         end
         pfc_pkg::ST_HOLD: begin
            // result register; next item may be taken as it leaves
            rsp_tvalid = 1'b1;
            if (rsp_tready) begin
               req_tready = 1'b1;
               if (req_tvalid) begin
                  cmd.load = 1'b1;
                  state_in = req_op ? pfc_pkg::ST_CLEAR : pfc_pkg::ST_INTEG;
               end else begin
                  state_in = pfc_pkg::ST_IDLE;
               end
            end
         end
         default: state_in = pfc_pkg::ST_IDLE;
      endcase
   end

endmodule

[rtl/pfc_datapath.sv]
// Datapath for the PID feedforward controller: config registers, state,
// one shared 33x33 signed multiplier, bit-serial divider and result register.
// Depends on pfc_pkg.
module pfc_datapath (
   input  logic                             clock,
   input  logic                             reset,
   input  pfc_pkg::cmd_type                 cmd,
   output pfc_pkg::sts_type                 sts,
   input  logic                             csr_we,
   input  logic [pfc_pkg::IdxWidth-1:0]     csr_index,
   input  logic [pfc_pkg::DataWidth-1:0]    csr_wdata,
   input  logic [pfc_pkg::DataWidth-1:0]    in_err,
   input  logic [pfc_pkg::DataWidth-1:0]    in_dt,
   input  logic [pfc_pkg::DataWidth-1:0]    in_tgt,
   output logic [pfc_pkg::DataWidth-1:0]    out_drive,
   output logic                             out_clamped
);
   localparam int DW = pfc_pkg::DataWidth;
   localparam int FB = pfc_pkg::FracBits;
   localparam int QW = DW + FB;

   logic [DW-1:0] gain_p_ff, gain_i_ff, gain_d_ff, gain_ff_ff;
   logic [pfc_pkg::LimWidth-1:0] int_lim_ff, out_lim_ff;
   logic [pfc_pkg::WgtWidth-1:0] weight_ff;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         gain_p_ff  <= '0;
         gain_i_ff  <= '0;
         gain_d_ff  <= '0;
         gain_ff_ff <= '0;
         int_lim_ff <= '1;
         out_lim_ff <= '1;
         weight_ff  <= pfc_pkg::WgtOne;
      end else if (csr_we) begin
         unique case (csr_index)
            pfc_pkg::RegGainP:  gain_p_ff  <= csr_wdata;
            pfc_pkg::RegGainI:  gain_i_ff  <= csr_wdata;
            pfc_pkg::RegGainD:  gain_d_ff  <= csr_wdata;
            pfc_pkg::RegGainFf: gain_ff_ff <= csr_wdata;
            pfc_pkg::RegIntLim: int_lim_ff <= csr_wdata[pfc_pkg::LimWidth-1:0];
            pfc_pkg::RegOutLim: out_lim_ff <= csr_wdata[pfc_pkg::LimWidth-1:0];
            pfc_pkg::RegWeight: weight_ff  <= csr_wdata[pfc_pkg::WgtWidth-1:0];
            default: ;
         endcase
      end
   end

   logic [DW-1:0] err_ff, dt_ff, tgt_ff;
   logic [DW-1:0] integ_ff, last_err_ff, last_der_ff;
   logic [DW-1:0] raw_ff;
   logic [65:0]   acc_ff;       // signed accumulator for EMA and output sum
   logic [DW-1:0] drive_ff;
   logic          clamped_ff;

   // divider registers: restoring, one quotient bit a cycle
   logic [QW-1:0] dividend_ff;  // shifts out dividend bits, shifts in quotient
   logic [DW-1:0] rem_ff;       // always below the step
   logic          neg_ff;
   logic [5:0]    cnt_ff;

   // shared multiplier: 33x33 signed (covers alpha and 1-alpha operands)
   logic signed [DW:0]   mul_a, mul_b;
   logic signed [65:0]   prod;
   logic signed [65:0]   prod_fl;
   logic [DW-1:0]        prod_sat;
   logic [pfc_pkg::WgtWidth-1:0] alpha;

   always_comb begin
      alpha = (weight_ff > pfc_pkg::WgtOne) ? pfc_pkg::WgtOne : weight_ff;
      mul_a = '0;
      mul_b = '0;
      unique case (1'b1)
         cmd.integ:   begin mul_a = {err_ff[DW-1], err_ff}; mul_b = {dt_ff[DW-1], dt_ff}; end
         cmd.ema_a:   begin
            mul_a = {{(DW+1-pfc_pkg::WgtWidth){1'b0}}, alpha};
            mul_b = {raw_ff[DW-1], raw_ff};
         end
         cmd.ema_b:   begin
            mul_a = {{(DW+1-pfc_pkg::WgtWidth){1'b0}}, pfc_pkg::WgtOne - alpha};
            mul_b = {last_der_ff[DW-1], last_der_ff};
         end
         cmd.term_p:  begin mul_a = {gain_p_ff[DW-1], gain_p_ff}; mul_b = {err_ff[DW-1], err_ff}; end
         cmd.term_i:  begin
            mul_a = {gain_i_ff[DW-1], gain_i_ff}; mul_b = {integ_ff[DW-1], integ_ff};
         end
         cmd.term_d:  begin
            mul_a = {gain_d_ff[DW-1], gain_d_ff}; mul_b = {last_der_ff[DW-1], last_der_ff};
         end
         cmd.term_ff: begin
            mul_a = {gain_ff_ff[DW-1], gain_ff_ff}; mul_b = {tgt_ff[DW-1], tgt_ff};
         end
         default: ;
      endcase
      prod     = mul_a * mul_b;
      prod_fl  = prod >>> FB;              // arithmetic shift floors
      prod_sat = pfc_pkg::sat66(prod_fl);
   end

   // error difference and divider helpers
   logic signed [DW:0]   diff_w;
   logic [DW-1:0]        diff_sat;
   logic [DW-1:0]        diff_mag;
   logic [DW:0]          rem_sh;
   logic [DW:0]          rem_sub;
   logic signed [QW:0]   quo_s;
   logic signed [65:0]   sum_i;
   logic [DW-1:0]        integ_sat;
   logic signed [DW:0]   lim_i;
   logic signed [65:0]   acc_s, acc_fl, lim_o;

   always_comb begin
      diff_w   = $signed({err_ff[DW-1], err_ff}) - $signed({last_err_ff[DW-1], last_err_ff});
      diff_sat = pfc_pkg::sat66(66'(diff_w));
      diff_mag = diff_sat[DW-1] ? (~diff_sat + 1'b1) : diff_sat;
      rem_sh   = {rem_ff, dividend_ff[QW-1]};
      rem_sub  = rem_sh - {1'b0, dt_ff};
      quo_s    = neg_ff ? -$signed({1'b0, dividend_ff}) : $signed({1'b0, dividend_ff});
      sum_i    = $signed({{34{integ_ff[DW-1]}}, integ_ff}) + $signed({{34{prod_sat[DW-1]}}, prod_sat});
      integ_sat = pfc_pkg::sat66(sum_i);
      lim_i    = $signed({2'b00, int_lim_ff});
      acc_s    = $signed(acc_ff);
      acc_fl   = acc_s >>> FB;
      lim_o    = $signed({35'd0, out_lim_ff});
   end

   assign sts.div_done = (cnt_ff == 6'(QW - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         integ_ff    <= '0;
         last_err_ff <= '0;
         last_der_ff <= '0;
         cnt_ff      <= '0;
      end else begin
         if (cmd.load) begin
            err_ff <= in_err;
            dt_ff  <= ($signed(in_dt) <= 0) ? pfc_pkg::DtDefault : in_dt;
            tgt_ff <= in_tgt;
         end
         if (cmd.clear) begin
            integ_ff    <= '0;
            last_err_ff <= '0;
            last_der_ff <= '0;
            drive_ff    <= '0;
            clamped_ff  <= 1'b0;
         end
         if (cmd.integ) integ_ff <= integ_sat;
         if (cmd.intclamp) begin
            if ($signed({integ_ff[DW-1], integ_ff}) > lim_i) integ_ff <= {1'b0, int_lim_ff};
            else if ($signed({integ_ff[DW-1], integ_ff}) < -lim_i)
               integ_ff <= DW'(-lim_i);
         end
         if (cmd.diff) begin
            dividend_ff <= {diff_mag, {FB{1'b0}}};
            rem_ff      <= '0;
            neg_ff      <= diff_sat[DW-1];
            cnt_ff      <= '0;
         end
         if (cmd.div_step) begin
            cnt_ff <= cnt_ff + 6'd1;
            if (!rem_sub[DW]) begin
               rem_ff      <= rem_sub[DW-1:0];
               dividend_ff <= {dividend_ff[QW-2:0], 1'b1};
            end else begin
               rem_ff      <= rem_sh[DW-1:0];
               dividend_ff <= {dividend_ff[QW-2:0], 1'b0};
            end
         end
         if (cmd.div_fin) raw_ff <= pfc_pkg::sat66(66'(quo_s));
         if (cmd.ema_a) acc_ff <= prod;
         if (cmd.ema_b) acc_ff <= acc_s + prod;
         if (cmd.ema_fin) begin
            last_der_ff <= pfc_pkg::sat66(acc_fl);
            last_err_ff <= err_ff;
         end
         if (cmd.term_p) acc_ff <= {{34{prod_sat[DW-1]}}, prod_sat};
         if (cmd.term_i || cmd.term_d || cmd.term_ff)
            acc_ff <= acc_s + $signed({{34{prod_sat[DW-1]}}, prod_sat});
         if (cmd.out_fin) begin
            if (acc_s > lim_o) begin
               drive_ff <= {1'b0, out_lim_ff}; clamped_ff <= 1'b1;
            end else if (acc_s < -lim_o) begin
               drive_ff <= DW'(-lim_o); clamped_ff <= 1'b1;
            end else begin
               drive_ff <= acc_ff[DW-1:0]; clamped_ff <= 1'b0;
            end
         end
      end
   end

   assign out_drive   = drive_ff;
   assign out_clamped = clamped_ff;

endmodule

[rtl/pid_feedforward_controller_core.sv]
// PID controller with filtered derivative and velocity feedforward, Q16.16.
// A clear goes through ST_CLEAR to the held result; a control update first runs a
// 48-step bit-serial divider plus 12 steps around one shared multiplier.
// One item at a time; the result is held in a register and the next item is taken in
// the cycle the result is accepted.
// Synchronous active-high reset: gains 0, limits max, weight 1.0, state zero.
module pid_feedforward_controller_core (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [95:0]  req_tdata,   // error_in[31:0], time_step[63:32], target_speed[95:64]
   input  logic         req_tuser,   // operation
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [31:0]  rsp_tdata,   // drive
   output logic         rsp_tuser,   // drive_clamped
   input  logic         csr_we,
   input  logic [2:0]   csr_index,
   input  logic [31:0]  csr_wdata
);
   pfc_pkg::cmd_type cmd;
   pfc_pkg::sts_type sts;

   pfc_ctrl u_ctrl (
      .clock, .reset, .req_tvalid, .req_tready, .req_op(req_tuser),
      .rsp_tvalid, .rsp_tready, .sts, .cmd
   );

   pfc_datapath u_dp (
      .clock, .reset, .cmd, .sts, .csr_we, .csr_index, .csr_wdata,
      .in_err(req_tdata[31:0]), .in_dt(req_tdata[63:32]), .in_tgt(req_tdata[95:64]),
      .out_drive(rsp_tdata), .out_clamped(rsp_tuser)
   );

endmodule

[sim/tb.sv]
// Testbench for pid_feedforward_controller_core: directed tables, then random updates and clears.
// Expected drive values come from a behavioral PID predictor or are typed in the table; depends on rtl/pfc_pkg.sv.
`timescale 1ns / 100ps

module tb;

   localparam bit OpUpdate = 1'b0;
   localparam bit OpClear  = 1'b1;
   localparam logic [pfc_pkg::IdxWidth-1:0] RegUnused = 3'd7;
   localparam longint FxOne = 65536;
   localparam longint FxMax = 64'sd2147483647;
   localparam longint FxMin = -64'sd2147483648;

   typedef struct {
      bit          op;
      logic [31:0] err;
      logic [31:0] dt;
      logic [31:0] tgt;
      bit          typed;   // expected drive typed in below
      logic [31:0] xdrive;
      bit          xclamp;
   } row_type;

   typedef struct {
      logic [31:0] drive;
      bit          clamp;
   } drive_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [95:0] req_tdata = '0;
   logic        req_tuser = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic        rsp_tuser;
   logic        csr_we = 1'b0;
   logic [2:0]  csr_index = '0;
   logic [31:0] csr_wdata = '0;

   // predictor copy of registers and state
   longint kp, ki, kd, kff, int_lim, out_lim, weight;
   longint integ_sum, prev_err, prev_deriv;

   drive_type drive_q[$];
   int     mismatches = 0;
   int     send_idle = 0;
   int     recv_idle = 0;
   int     hold_left = 0;

   pid_feedforward_controller_core DUT (.*);

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   initial begin
      #5ms;
      $display("FAIL pid_feedforward_controller_core");
      $finish;
   end

   function automatic longint sat32(longint v);
      if (v > FxMax) return FxMax;
      if (v < FxMin) return FxMin;
      return v;
   endfunction

   function automatic longint fx_mult(longint a, longint b);
      return sat32((a * b) >>> 16);
   endfunction

   // one controller update on the predictor state
   function automatic drive_type pid_predict(bit op, logic [31:0] e, logic [31:0] d,
                                             logic [31:0] t);
      drive_type r;
      longint err, dt, tgt, raw, alpha, filt, sum;
      r.drive = '0;
      r.clamp = 1'b0;
      if (op == OpClear) begin
         integ_sum = 0;
         prev_err = 0;
         prev_deriv = 0;
         return r;
      end
      err = longint'(signed'(e));
      dt  = longint'(signed'(d));
      tgt = longint'(signed'(t));
      if (dt <= 0) dt = longint'(pfc_pkg::DtDefault);
      integ_sum = sat32(integ_sum + fx_mult(err, dt));
      if (integ_sum > int_lim) integ_sum = int_lim;
      else if (integ_sum < -int_lim) integ_sum = -int_lim;
      raw = sat32((sat32(err - prev_err) * FxOne) / dt);
      alpha = (weight > FxOne) ? FxOne : weight;
      filt = sat32((alpha * raw + (FxOne - alpha) * prev_deriv) >>> 16);
      prev_err = err;
      prev_deriv = filt;
      sum = fx_mult(kp, err) + fx_mult(ki, integ_sum) + fx_mult(kd, filt)
          + fx_mult(kff, tgt);
      if (sum > out_lim) begin
         sum = out_lim;
         r.clamp = 1'b1;
      end else if (sum < -out_lim) begin
         sum = -out_lim;
         r.clamp = 1'b1;
      end
      r.drive = sum[31:0];
      return r;
   endfunction

   // register write, entered and left at a falling edge
   task automatic csr_write(logic [2:0] idx, logic [31:0] val);
      csr_we = 1'b1;
      csr_index = idx;
      csr_wdata = val;
      case (idx)
         pfc_pkg::RegGainP:  kp  = longint'(signed'(val));
         pfc_pkg::RegGainI:  ki  = longint'(signed'(val));
         pfc_pkg::RegGainD:  kd  = longint'(signed'(val));
         pfc_pkg::RegGainFf: kff = longint'(signed'(val));
         pfc_pkg::RegIntLim: int_lim = longint'(val[30:0]);
         pfc_pkg::RegOutLim: out_lim = longint'(val[30:0]);
         pfc_pkg::RegWeight: weight  = longint'(val[16:0]);
         default: ;
      endcase
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   // drain all pending results, then let the core settle
   task automatic wait_drain();
      while (drive_q.size() != 0) @(negedge clock);
      repeat (70) @(negedge clock);
   endtask

   // offer one transaction; valid stays high afterwards until the caller or the next call changes it
   task automatic send_req(row_type r);
      drive_type x;
      while ($urandom_range(0, 99) < send_idle) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tuser = r.op;
      req_tdata = {r.tgt, r.dt, r.err};
      do @(posedge clock); while (!req_tready);
      x = pid_predict(r.op, r.err, r.dt, r.tgt);
      if (r.typed) begin
         x.drive = r.xdrive;
         x.clamp = r.xclamp;
      end
      drive_q.push_back(x);
      @(negedge clock);
   endtask

   function automatic logic [31:0] rand_fx();
      case ($urandom_range(0, 7))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2, 3: return $urandom;
         default: return 32'($urandom_range(0, 524288)) - 32'd262144;
      endcase
   endfunction

   function automatic logic [31:0] rand_limit();
      case ($urandom_range(0, 4))
         0: return 32'd0;
         1: return 32'h7FFF_FFFF;
         2: return $urandom;
         default: return 32'($urandom_range(0, 1 << 22));
      endcase
   endfunction

   function automatic logic [31:0] rand_weight();
      case ($urandom_range(0, 4))
         0: return 32'd0;
         1: return 32'd65536;
         2: return 32'h1FFFF;
         default: return 32'($urandom_range(0, 65536));
      endcase
   endfunction

   function automatic row_type rand_row();
      row_type r;
      r.op = ($urandom_range(0, 9) == 0) ? OpClear : OpUpdate;
      r.err = rand_fx();
      case ($urandom_range(0, 5))
         0: r.dt = 32'($urandom_range(0, 3)) - 32'd1;  // negative, zero or tiny
         1: r.dt = $urandom;
         default: r.dt = 32'($urandom_range(1, 1 << 17));
      endcase
      r.tgt = rand_fx();
      r.typed = 1'b0;
      r.xdrive = '0;
      r.xclamp = 1'b0;
      return r;
   endfunction

   // receiver back-pressure, with an optional long hold-off
   initial begin
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready = 1'b0;
         end else begin
            rsp_tready = ($urandom_range(0, 99) >= recv_idle);
         end
      end
   end

   // compare each result transaction with the oldest expected drive
   always @(posedge clock) begin
      drive_type x;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (drive_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result: drive %h clamp %b", rsp_tdata, rsp_tuser);
         end else begin
            x = drive_q.pop_front();
            if (rsp_tdata !== x.drive || rsp_tuser !== x.clamp) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: drive exp %h got %h, clamp exp %b got %b",
                           x.drive, rsp_tdata, x.clamp, rsp_tuser);
            end
         end
      end
   end

   initial begin
      row_type dir_a[10];
      row_type dir_b[5];
      row_type r;
      int   n;

      kp = 0; ki = 0; kd = 0; kff = 0;
      int_lim = FxMax; out_lim = FxMax; weight = FxOne;
      integ_sum = 0; prev_err = 0; prev_deriv = 0;

      // zero gains after reset: every drive is zero, never clamped
      dir_a = '{
         '{OpUpdate, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1, 32'd0, 0},
         '{OpUpdate, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1, 32'd0, 0},
         '{OpUpdate, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1, 32'd0, 0},
         '{OpUpdate, 32'h0000_0001, 32'h0000_0001, 32'h0000_0001, 1, 32'd0, 0},
         '{OpUpdate, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 32'd0, 0},
         '{OpClear,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 32'd0, 0},
         '{OpUpdate, 32'h1234_5678, 32'h0001_0000, 32'hDEAD_BEEF, 1, 32'd0, 0},
         '{OpUpdate, 32'h8000_0000, 32'h0000_0001, 32'h7FFF_FFFF, 1, 32'd0, 0},
         '{OpUpdate, 32'h7FFF_FFFF, 32'h0000_0001, 32'h8000_0000, 1, 32'd0, 0},
         '{OpClear,  32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1, 32'd0, 0}
      };
      // unit P gain, zero output limit: any nonzero sum clamps to zero
      dir_b = '{
         '{OpUpdate, 32'h0001_0000, 32'h0001_0000, 32'h0, 1, 32'd0, 1},
         '{OpUpdate, 32'h0000_0000, 32'h0001_0000, 32'h0, 1, 32'd0, 0},
         '{OpUpdate, 32'h8000_0000, 32'h0000_0000, 32'h0, 1, 32'd0, 1},
         '{OpClear,  32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0, 1, 32'd0, 0},
         '{OpUpdate, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 1, 32'd0, 1}
      };

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (dir_a[i]) send_req(dir_a[i]);
      req_tvalid = 1'b0;
      wait_drain();
      csr_write(pfc_pkg::RegGainP, 32'h0001_0000);
      csr_write(pfc_pkg::RegOutLim, 32'd0);
      foreach (dir_b[i]) send_req(dir_b[i]);
      req_tvalid = 1'b0;
      wait_drain();

      // extreme gains and no filtering, checked by the predictor
      csr_write(pfc_pkg::RegGainP, 32'h7FFF_FFFF);
      csr_write(pfc_pkg::RegGainI, 32'h8000_0000);
      csr_write(pfc_pkg::RegGainD, 32'h7FFF_FFFF);
      csr_write(pfc_pkg::RegGainFf, 32'h8000_0000);
      csr_write(pfc_pkg::RegIntLim, 32'h7FFF_FFFF);
      csr_write(pfc_pkg::RegOutLim, 32'h7FFF_FFFF);
      csr_write(pfc_pkg::RegWeight, 32'h1FFFF);
      csr_write(RegUnused, $urandom);
      foreach (dir_a[i]) begin
         r = dir_a[i];
         r.typed = 1'b0;
         send_req(r);
      end
      req_tvalid = 1'b0;

      // random phases, each with its own register setting, with idle patterns that vary between phases
      for (int ph = 0; ph < 6; ph++) begin
         wait_drain();
         csr_write(pfc_pkg::RegGainP, rand_fx());
         csr_write(pfc_pkg::RegGainI, rand_fx());
         csr_write(pfc_pkg::RegGainD, rand_fx());
         csr_write(pfc_pkg::RegGainFf, rand_fx());
         csr_write(pfc_pkg::RegIntLim, rand_limit());
         csr_write(pfc_pkg::RegOutLim, rand_limit());
         csr_write(pfc_pkg::RegWeight, rand_weight());
         if (ph == 4) csr_write(RegUnused, $urandom);
         send_idle = (ph < 2) ? 14 : (ph < 4) ? 47 : 0;
         recv_idle = (ph < 2) ? 47 : (ph < 4) ? 14 : 0;
         if (ph == 1) hold_left = 400;
         n = 90;
         for (int k = 0; k < n; k++) begin
            if (ph == 3 && k == n / 2) begin
               req_tvalid = 1'b0;
               while (drive_q.size() != 0) @(negedge clock);
            end
            send_req(rand_row());
         end
         req_tvalid = 1'b0;
      end

      while (drive_q.size() != 0) @(negedge clock);
      repeat (70) @(negedge clock);
      if (mismatches == 0) begin
         $display("PASS pid_feedforward_controller_core");
      end else begin
         $display("FAIL pid_feedforward_controller_core");
      end
      $finish;
   end

endmodule
